@@ rtl/bmorph3_pkg.sv @@
// Shared constants for the 3x3 binary morphology block: register map,
// mode and op codes, fixed field widths. No dependencies.
package bmorph3_pkg;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	localparam int TDATA_W      = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int MODE_W       = 2;

	// Row counter and frame-position widths (height tops out at 4096).
	localparam int ROW_W      = 12;
	localparam int POS_W      = 13;
	localparam int HEIGHT_MAX = 4096;
	localparam int SIZE_MIN   = 3;

	localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

endpackage

@@ rtl/binary_morphology_3x3.sv @@
// 3x3 binary erosion / dilation / close on a raster pixel stream.
// Depends on bmorph3_pkg (register map, codes, widths).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata[0]=pixel_object, tuser=op
//  m_*     | out | m_tvalid/m_tready  | tdata[0]=out_object, tlast=out_last
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// One item per clock while the output is not stalled: a request is taken into
// the s1 register (line memory read issued on the same edge), windowed and
// written back in s1, and its result then moves into the output register,
// which drives m_tvalid.
// Reset clears counters, windows and valids; line memories start unwritten.
// A stalled output holds s1 only if s1 carries a result; otherwise flows on.
module binary_morphology_3x3 #(
	parameter int MAX_WIDTH = bmorph3_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bmorph3_pkg::TDATA_W-1:0]     s_tdata,   // [0] pixel_object
	input  logic                                s_tuser,   // [0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bmorph3_pkg::TDATA_W-1:0]     m_tdata,   // [0] out_object
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [bmorph3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmorph3_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bmorph3_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int CX_W   = WID_W + 1;
	localparam int PEND_W = $clog2(2 * MAX_WIDTH + 3);

	function automatic logic [POS_W-1:0] ctr_row(input logic [POS_W-1:0] r,
			input logic c_nz, input logic [POS_W-1:0] h);
		logic [POS_W-1:0] res;
		if (c_nz) begin
			res = (r >= POS_W'(1)) ? r - POS_W'(1) : r + h - POS_W'(1);
		end else begin
			res = (r >= POS_W'(2)) ? r - POS_W'(2) : r + h - POS_W'(2);
		end
		return res;
	endfunction

	function automatic logic [COL_W-1:0] ctr_col(input logic [COL_W-1:0] c,
			input logic [WID_W-1:0] w);
		return (c != '0) ? c - COL_W'(1) : COL_W'(w - WID_W'(1));
	endfunction

	function automatic logic is_int(input logic [POS_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [WID_W-1:0] w,
			input logic [POS_W-1:0] h);
		return (r != '0) && ({1'b0, r} + (POS_W+1)'(2) <= {1'b0, h}) &&
			(c != '0) && (CX_W'(c) + CX_W'(2) <= CX_W'(w));
	endfunction

	// configuration
	logic [WIDTH_CFG_W-1:0]  width_q;
	logic [HEIGHT_CFG_W-1:0] height_q;
	logic [MODE_W-1:0]       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			mode_q   <= MODE_ERODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_CFG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_CFG_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WID_W-1:0] w_eff;
	logic [POS_W-1:0] h_eff;
	logic             dil, two;
	logic [PEND_W-1:0] lat;

	always_comb begin
		if (32'(width_q) < 32'(SIZE_MIN)) w_eff = WID_W'(SIZE_MIN);
		else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
		else w_eff = WID_W'(width_q);
		if (height_q < POS_W'(SIZE_MIN)) h_eff = POS_W'(SIZE_MIN);
		else if (height_q > POS_W'(HEIGHT_MAX)) h_eff = POS_W'(HEIGHT_MAX);
		else h_eff = height_q;
		dil = (mode_q != MODE_ERODE);
		two = (mode_q >= MODE_CLOSE);
		lat = two ? (PEND_W'(w_eff) + PEND_W'(1)) << 1 : PEND_W'(w_eff) + PEND_W'(1);
	end

	// position counters and owed-result count
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PEND_W-1:0] pending_q;

	logic s_acc, drain, take, emit_in;
	logic [POS_W-1:0] r_in, ra, rb;
	logic [COL_W-1:0] ca, cb;
	logic [CX_W-1:0]  col_inc;
	logic [POS_W-1:0] row_inc;

	always_comb begin
		s_acc   = s_tvalid & s_tready;
		drain   = (s_tuser == OP_DRAIN);
		take    = s_acc && !(drain && pending_q == '0);
		emit_in = drain || (pending_q >= lat);
		r_in    = POS_W'(row_q);
		ca      = ctr_col(col_q, w_eff);
		ra      = ctr_row(r_in, col_q != '0, h_eff);
		cb      = ctr_col(ca, w_eff);
		rb      = ctr_row(ra, ca != '0, h_eff);
		col_inc = CX_W'(col_q) + CX_W'(1);
		row_inc = r_in + POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			pending_q <= '0;
		end else if (take) begin
			if (drain && pending_q == PEND_W'(1)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= CX_W'(w_eff)) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
			if (drain) pending_q <= pending_q - PEND_W'(1);
			else if (pending_q < lat) pending_q <= pending_q + PEND_W'(1);
		end
	end

	// s1: item with its line-memory taps and position flags
	logic             valid_s1, emit_s1;
	logic [COL_W-1:0] col_s1, ca_s1;
	logic             v_s1, dil_s1, two_s1, clr_mid_s1, clr_top_s1, int1_s1;
	logic             mlo_s1, mhi_s1, eok1_s1, eok2_s1, last_s1;
	logic [1:0]       rd1_s1, rd2_s1;   // [0] row above, [1] two rows above
	logic [8:0]       win1_q, win2_q;

	logic out_valid_q, out_object_q, out_last_q;
	logic out_free, adv1;
	logic top1, mid1, v1, res1, res2, res;
	logic [8:0] nwin1, nwin2, dmask;
	logic [1:0] wdata1, wdata2;
	logic       wr2;

	always_comb begin
		out_free = !out_valid_q || m_tready;
		adv1     = valid_s1 && (!emit_s1 || out_free);
		s_tready = !valid_s1 || adv1;

		top1  = rd1_s1[1] & ~clr_top_s1;
		mid1  = rd1_s1[0] & ~clr_mid_s1;
		v1    = v_s1 & (~dil_s1 | int1_s1);
		nwin1 = {v1, mid1, top1, win1_q[8:3]};
		dmask = {~{3{mhi_s1}}, 3'b111, ~{3{mlo_s1}}};
		res1  = dil_s1 ? |(nwin1 & dmask) : (eok1_s1 & (&nwin1));
		nwin2 = {res1, rd2_s1[0], rd2_s1[1], win2_q[8:3]};
		res2  = eok2_s1 & (&nwin2);
		res   = two_s1 ? res2 : res1;

		wdata1 = {mid1, v1};
		wdata2 = {rd2_s1[0], res1};
		wr2    = adv1 && two_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			emit_s1     <= 1'b0;
			win1_q      <= '0;
			win2_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= take;
				emit_s1  <= emit_in;
			end
			if (adv1) begin
				win1_q <= nwin1;
				if (two_s1) win2_q <= nwin2;
			end
			if (out_free) out_valid_q <= adv1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s_tready) begin
			col_s1     <= col_q;
			ca_s1      <= ca;
			v_s1       <= !drain && s_tdata[0];
			dil_s1     <= dil;
			two_s1     <= two;
			clr_mid_s1 <= dil && row_q == '0;
			clr_top_s1 <= dil && row_q == ROW_W'(1);
			int1_s1    <= is_int(r_in, col_q, w_eff, h_eff);
			mlo_s1     <= (ca == '0);
			mhi_s1     <= (WID_W'(ca) == w_eff - WID_W'(1));
			eok1_s1    <= is_int(ra, ca, w_eff, h_eff);
			eok2_s1    <= is_int(rb, cb, w_eff, h_eff);
			last_s1    <= two ? (rb == h_eff - POS_W'(1) && WID_W'(cb) == w_eff - WID_W'(1))
				: (ra == h_eff - POS_W'(1) && WID_W'(ca) == w_eff - WID_W'(1));
		end
		if (adv1 && emit_s1 && out_free) begin
			out_object_q <= res;
			out_last_q   <= last_s1;
		end
	end

	// line memories: one entry per column holding the two previous rows
	logic [1:0] line1_mem [MAX_WIDTH];
	logic [1:0] line2_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (adv1) line1_mem[col_s1] <= wdata1;
		if (wr2) line2_mem[ca_s1] <= wdata2;
		if (take && s_tready) begin
			// bypass covers a frame restart landing on the column just written
			rd1_s1 <= (adv1 && col_s1 == col_q) ? wdata1 : line1_mem[col_q];
			rd2_s1 <= (wr2 && ca_s1 == ca) ? wdata2 : line2_mem[ca];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-1){1'b0}}, out_object_q};
	assign m_tlast  = out_last_q;

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && drain && pending_q == '0) |=> ($stable(col_q) && $stable(row_q)))
		else $error("empty drain moved the position counters");

	a_drain_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && drain && pending_q == PEND_W'(1)) |=> (col_q == '0 && row_q == '0))
		else $error("counters not restarted after final drain");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CX_W'(col_q) < CX_W'(MAX_WIDTH))
		else $error("column counter beyond line memory depth");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("request taken while result path is blocked");

	a_emit_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !drain && emit_in) |-> (pending_q != '0))
		else $error("result emitted with nothing owed");

endmodule
